FILE: src/rsw_pkg.sv
// ----------------------------------------------------------------------------
// rsw_pkg
// Shared types and constants of the reliable send window.
// ----------------------------------------------------------------------------
package rsw_pkg;

  localparam int DefWindowDepth = 32;
  localparam int DefBurstLimit  = 16;
  localparam int DefaultWindow  = 16;

  localparam logic [5:0]  RstWindowLimit = 6'd16;
  localparam logic [15:0] RstSegmentSize = 16'd1400;
  localparam logic [31:0] RstSendTimeout = 32'd1000;
  localparam logic [15:0] RstSendDelay   = 16'd10;

  typedef enum logic [1:0] {
    FUNC_ADD  = 2'd0,
    FUNC_ACK  = 2'd1,
    FUNC_NACK = 2'd2,
    FUNC_TICK = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    KIND_XMIT = 2'd0,
    KIND_CMPL = 2'd1,
    KIND_DONE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REG_WINDOW_LIMIT = 2'd0,
    REG_SEGMENT_SIZE = 2'd1,
    REG_SEND_TIMEOUT = 2'd2,
    REG_SEND_DELAY   = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD,
    ST_MRD,
    ST_MPROC,
    ST_RRD,
    ST_RPROC,
    ST_SRD,
    ST_SPROC,
    ST_HPROC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        lost;
    logic        ackd;
    logic        first;
    logic        lastm;
    logic [31:0] send_time;
    logic [31:0] message;
    logic [15:0] offset;
    logic [15:0] length;
  } entry_t;

  typedef struct packed {
    kind_t       kind;
    logic [30:0] seq;
    logic [31:0] msg_number;
    logic [15:0] byte_offset;
    logic [15:0] byte_length;
    logic        first_in_msg;
    logic        last_in_msg;
    logic [15:0] accepted_bytes;
    logic [31:0] wake_time;
    logic        last;
  } result_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

FILE: src/rsw_ram.sv
// ----------------------------------------------------------------------------
// rsw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rsw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_r <= mem[ra];
    end
  end

  assign rd = rd_r;

endmodule

FILE: src/reliable_send_window_core.sv
// ----------------------------------------------------------------------------
// reliable_send_window_core
// Sender window of a reliable datagram link with selective acknowledgement.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  in      | in_valid/in_stall  | func, msg_length, msg_number, range, now
//  out     | out_valid/out_stall| kind, seq, msg, offset, length, flags, ...
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  An item runs through steps in order: the take, then the mark and send
//  walks, which read a window entry and then modify and write it back; the
//  retire walk reads the head entry and advances the head; add appends one
//  segment per step; plus the walk exit, head read and done steps.
//  Reset is synchronous; the window comes up empty, no RAM clear is needed.
//  Output stall holds the walk at the entry waiting to transfer.
// ----------------------------------------------------------------------------
module reliable_send_window_core #(
  parameter int WINDOW_DEPTH = rsw_pkg::DefWindowDepth,
  parameter int BURST_LIMIT  = rsw_pkg::DefBurstLimit
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [15:0] in_msg_length,
  input  logic [31:0] in_msg_number,
  input  logic [30:0] in_range_first,
  input  logic [30:0] in_range_last,
  input  logic [31:0] in_now,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [30:0] out_seq,
  output logic [31:0] out_msg_number,
  output logic [15:0] out_byte_offset,
  output logic [15:0] out_byte_length,
  output logic        out_first_in_msg,
  output logic        out_last_in_msg,
  output logic [15:0] out_accepted_bytes,
  output logic [31:0] out_wake_time,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int SW = $clog2(WINDOW_DEPTH);
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int BW = $clog2(BURST_LIMIT + 1);
  localparam int EW = $bits(rsw_pkg::entry_t);
  localparam int DefLim = (WINDOW_DEPTH < rsw_pkg::DefaultWindow) ?
                          WINDOW_DEPTH : rsw_pkg::DefaultWindow;

  logic [5:0]  wl_r;
  logic [15:0] ss_r;
  logic [31:0] to_r;
  logic [15:0] sd_r;

  rsw_pkg::state_t state_r, state_nxt;
  rsw_pkg::func_t  fn_r;
  logic [15:0] len_r;
  logic [31:0] msg_r, now_r;
  logic [30:0] rf_r, rl_r;
  logic [30:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [SW-1:0] hslot_r, hslot_nxt;
  logic [31:0] prev_r, prev_nxt, dl_r, dl_nxt;
  logic        armed_r, armed_nxt;
  logic [CW-1:0] idx_r, idx_nxt, lim_r, lim_nxt, csnap_r, csnap_nxt;
  logic [BW-1:0] sent_r, sent_nxt;
  logic [15:0] pos_r, pos_nxt, acc_r, acc_nxt;
  logic [31:0] wake_r, wake_nxt;
  logic        run_r, run_nxt;

  logic        ov_r;
  rsw_pkg::result_t ores_r, emit_res;
  logic        emit, out_ok;

  logic          ram_we, ram_re;
  logic [SW-1:0] ram_wa, ram_ra;
  rsw_pkg::entry_t ram_wd, ram_rd;
  logic [EW-1:0]   ram_rd_bits;

  logic [30:0]   diff;
  logic [CW-1:0] cnt;
  logic [SW:0]   ssum, tsum, hsum;
  logic [SW-1:0] slot_i, slot_t;
  logic [15:0]   rem, seg;
  logic [16:0]   pend;
  logic [30:0]   seq_i;
  logic [32:0]   due;
  logic [CW-1:0] limc;

  assign diff   = tail_r - head_r;
  assign cnt    = diff[CW-1:0];
  assign ssum   = {1'b0, hslot_r} + (SW+1)'(idx_r);
  assign slot_i = (ssum >= (SW+1)'(WINDOW_DEPTH)) ?
                  SW'(ssum - (SW+1)'(WINDOW_DEPTH)) : ssum[SW-1:0];
  assign tsum   = {1'b0, hslot_r} + (SW+1)'(cnt);
  assign slot_t = (tsum >= (SW+1)'(WINDOW_DEPTH)) ?
                  SW'(tsum - (SW+1)'(WINDOW_DEPTH)) : tsum[SW-1:0];
  assign hsum   = {1'b0, hslot_r} + (SW+1)'(1);
  assign rem    = len_r - pos_r;
  assign seg    = (ss_r == 16'd0 || ss_r > rem) ? rem : ss_r;
  assign pend   = {1'b0, pos_r} + {1'b0, seg};
  assign seq_i  = head_r + 31'(idx_r);
  assign ram_rd = rsw_pkg::entry_t'(ram_rd_bits);
  assign due    = {1'b0, ram_rd.send_time} + {1'b0, to_r};
  assign limc   = (32'(wl_r) > 32'(WINDOW_DEPTH)) ? CW'(WINDOW_DEPTH) : CW'(wl_r);
  assign out_ok = !ov_r || !out_stall;

  assign in_stall  = (state_r != rsw_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  rsw_ram #(.WIDTH(EW), .DEPTH(WINDOW_DEPTH)) u_ram (
    .clk (clk),
    .we  (ram_we),
    .wa  (ram_wa),
    .wd  (EW'(ram_wd)),
    .re  (ram_re),
    .ra  (ram_ra),
    .rd  (ram_rd_bits)
  );

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    hslot_nxt = hslot_r;
    prev_nxt  = prev_r;
    dl_nxt    = dl_r;
    armed_nxt = armed_r;
    idx_nxt   = idx_r;
    lim_nxt   = lim_r;
    csnap_nxt = csnap_r;
    sent_nxt  = sent_r;
    pos_nxt   = pos_r;
    acc_nxt   = acc_r;
    wake_nxt  = wake_r;
    run_nxt   = run_r;
    ram_we    = 1'b0;
    ram_wa    = slot_i;
    ram_wd    = ram_rd;
    ram_re    = 1'b0;
    ram_ra    = slot_i;
    emit      = 1'b0;
    emit_res  = '0;
    unique case (state_r)
      rsw_pkg::ST_IDLE: begin
        if (in_valid) begin
          idx_nxt   = '0;
          sent_nxt  = '0;
          pos_nxt   = '0;
          acc_nxt   = '0;
          wake_nxt  = '0;
          run_nxt   = 1'b0;
          csnap_nxt = cnt;
          lim_nxt   = (limc == '0 && cnt == '0) ? CW'(DefLim) : limc;
          priority case (rsw_pkg::func_t'(in_func))
            rsw_pkg::FUNC_ADD:  state_nxt = rsw_pkg::ST_ADD;
            rsw_pkg::FUNC_TICK: begin
              if (armed_r && dl_r <= in_now) begin
                armed_nxt = 1'b0;
                state_nxt = rsw_pkg::ST_MRD;
              end else begin
                state_nxt = rsw_pkg::ST_SRD;
              end
            end
            default: state_nxt = rsw_pkg::ST_MRD;
          endcase
        end
      end
      rsw_pkg::ST_ADD: begin
        if (cnt < lim_r && pos_r < len_r) begin
          ram_we = 1'b1;
          ram_wa = slot_t;
          ram_wd = '{lost: 1'b1, ackd: 1'b0, first: (prev_r != msg_r),
                     lastm: (pend == {1'b0, len_r}), send_time: now_r,
                     message: msg_r, offset: pos_r, length: seg};
          prev_nxt = msg_r;
          tail_nxt = tail_r + 31'd1;
          pos_nxt  = pend[15:0];
        end else begin
          acc_nxt   = pos_r;
          state_nxt = rsw_pkg::ST_SRD;
        end
      end
      rsw_pkg::ST_MRD: begin
        if (idx_r < csnap_r) begin
          ram_re    = 1'b1;
          state_nxt = rsw_pkg::ST_MPROC;
        end else if (fn_r == rsw_pkg::FUNC_ACK) begin
          state_nxt = rsw_pkg::ST_RRD;
        end else begin
          idx_nxt   = '0;
          state_nxt = rsw_pkg::ST_SRD;
        end
      end
      rsw_pkg::ST_MPROC: begin
        if (fn_r == rsw_pkg::FUNC_TICK) begin
          if (!ram_rd.ackd && due < {1'b0, now_r}) begin
            ram_we = 1'b1;
            ram_wd.lost = 1'b1;
          end
        end else if (seq_i >= rf_r && seq_i <= rl_r) begin
          ram_we = 1'b1;
          if (fn_r == rsw_pkg::FUNC_ACK) ram_wd.ackd = 1'b1;
          else ram_wd.lost = 1'b1;
        end
        idx_nxt   = idx_r + CW'(1);
        state_nxt = rsw_pkg::ST_MRD;
      end
      rsw_pkg::ST_RRD: begin
        idx_nxt = '0;
        ram_ra  = hslot_r;
        if (cnt != '0) begin
          ram_re    = 1'b1;
          state_nxt = rsw_pkg::ST_RPROC;
        end else begin
          state_nxt = run_r ? rsw_pkg::ST_SRD : rsw_pkg::ST_DONE;
        end
      end
      rsw_pkg::ST_RPROC: begin
        if (!ram_rd.ackd) begin
          state_nxt = run_r ? rsw_pkg::ST_SRD : rsw_pkg::ST_DONE;
        end else if (!ram_rd.lastm || out_ok) begin
          emit                = ram_rd.lastm;
          emit_res.kind       = rsw_pkg::KIND_CMPL;
          emit_res.msg_number = ram_rd.message;
          head_nxt  = head_r + 31'd1;
          hslot_nxt = (hsum >= (SW+1)'(WINDOW_DEPTH)) ? '0 : hsum[SW-1:0];
          run_nxt   = 1'b1;
          state_nxt = rsw_pkg::ST_RRD;
        end
      end
      rsw_pkg::ST_SRD: begin
        if (idx_r < cnt && sent_r < BW'(BURST_LIMIT)) begin
          ram_re    = 1'b1;
          state_nxt = rsw_pkg::ST_SPROC;
        end else begin
          wake_nxt = rsw_pkg::sat_add(now_r, (sent_r != '0) ? {16'd0, sd_r} : to_r);
          if (cnt != '0) begin
            ram_re    = 1'b1;
            ram_ra    = hslot_r;
            state_nxt = rsw_pkg::ST_HPROC;
          end else begin
            state_nxt = rsw_pkg::ST_DONE;
          end
        end
      end
      rsw_pkg::ST_SPROC: begin
        if (!ram_rd.lost) begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = rsw_pkg::ST_SRD;
        end else if (out_ok) begin
          emit                  = 1'b1;
          emit_res.kind         = rsw_pkg::KIND_XMIT;
          emit_res.seq          = seq_i;
          emit_res.msg_number   = ram_rd.message;
          emit_res.byte_offset  = ram_rd.offset;
          emit_res.byte_length  = ram_rd.length;
          emit_res.first_in_msg = ram_rd.first;
          emit_res.last_in_msg  = ram_rd.lastm;
          ram_we              = 1'b1;
          ram_wd.lost         = 1'b0;
          ram_wd.send_time    = now_r;
          sent_nxt  = sent_r + BW'(1);
          idx_nxt   = idx_r + CW'(1);
          state_nxt = rsw_pkg::ST_SRD;
        end
      end
      rsw_pkg::ST_HPROC: begin
        dl_nxt    = rsw_pkg::sat_add(ram_rd.send_time, to_r);
        armed_nxt = 1'b1;
        state_nxt = rsw_pkg::ST_DONE;
      end
      rsw_pkg::ST_DONE: begin
        if (out_ok) begin
          emit                    = 1'b1;
          emit_res.kind           = rsw_pkg::KIND_DONE;
          emit_res.accepted_bytes = acc_r;
          emit_res.wake_time      = wake_r;
          emit_res.last           = 1'b1;
          state_nxt = rsw_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rsw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rsw_pkg::ST_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      hslot_r <= '0;
      prev_r  <= '0;
      dl_r    <= '0;
      armed_r <= 1'b0;
      ov_r    <= 1'b0;
      wl_r    <= rsw_pkg::RstWindowLimit;
      ss_r    <= rsw_pkg::RstSegmentSize;
      to_r    <= rsw_pkg::RstSendTimeout;
      sd_r    <= rsw_pkg::RstSendDelay;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      hslot_r <= hslot_nxt;
      prev_r  <= prev_nxt;
      dl_r    <= dl_nxt;
      armed_r <= armed_nxt;
      if (emit) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (rsw_pkg::reg_idx_t'(cfg_index))
          rsw_pkg::REG_WINDOW_LIMIT: wl_r <= cfg_data[5:0];
          rsw_pkg::REG_SEGMENT_SIZE: ss_r <= cfg_data[15:0];
          rsw_pkg::REG_SEND_TIMEOUT: to_r <= cfg_data;
          rsw_pkg::REG_SEND_DELAY:   sd_r <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    lim_r   <= lim_nxt;
    csnap_r <= csnap_nxt;
    sent_r  <= sent_nxt;
    pos_r   <= pos_nxt;
    acc_r   <= acc_nxt;
    wake_r  <= wake_nxt;
    run_r   <= run_nxt;
    if (emit) ores_r <= emit_res;
    if (in_valid && !in_stall) begin
      fn_r  <= rsw_pkg::func_t'(in_func);
      len_r <= in_msg_length;
      msg_r <= in_msg_number;
      rf_r  <= in_range_first;
      rl_r  <= in_range_last;
      now_r <= in_now;
    end
  end

  assign out_valid          = ov_r;
  assign out_kind           = ores_r.kind;
  assign out_seq            = ores_r.seq;
  assign out_msg_number     = ores_r.msg_number;
  assign out_byte_offset    = ores_r.byte_offset;
  assign out_byte_length    = ores_r.byte_length;
  assign out_first_in_msg   = ores_r.first_in_msg;
  assign out_last_in_msg    = ores_r.last_in_msg;
  assign out_accepted_bytes = ores_r.accepted_bytes;
  assign out_wake_time      = ores_r.wake_time;
  assign out_last           = ores_r.last;

`ifndef SYNTH
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while busy");
  a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
    diff <= 31'(WINDOW_DEPTH))
    else $error("window overfilled");
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_wa != ram_ra))
    else $error("entry read and written together");
`endif

endmodule
